// ===== src/dcmh_pkg.sv =====
`timescale 1ns / 1ps

package dcmh_pkg;

	localparam int unsigned WORD_W    = 32;
	localparam int unsigned TDATA_W   = 64;
	localparam int unsigned CFG_IDX_W = 1;
	localparam int unsigned STEP_W    = 6;

	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(52);

	localparam logic [WORD_W-1:0] KEY_A1_OFS = 32'h69FB_0000;
	localparam logic [WORD_W-1:0] KEY_A2_OFS = 32'h13DB_0000;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_KEY_LOW  = 1'b0,
		REG_KEY_HIGH = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef enum logic [2:0] {
		KEY_NONE,
		KEY_A1,
		KEY_A2,
		KEY_B1,
		KEY_B2
	} key_sel_t;

	typedef enum logic [3:0] {
		ALU_NOP,
		ALU_LOAD,
		ALU_ADD,
		ALU_SUB,
		ALU_MOVE,
		ALU_XA,
		ALU_XB,
		ALU_R3A,
		ALU_R3B,
		ALU_FINA,
		ALU_FINB,
		ALU_DONE
	} alu_t;

	typedef struct packed {
		logic                mul_en;
		key_sel_t            key_sel;
		logic [WORD_W-1:0]   coef;
		logic                use_hi;
		alu_t                alu;
	} uop_t;

	function automatic uop_t op_f(input alu_t a);
		uop_t u;
		u.mul_en  = 1'b0;
		u.key_sel = KEY_NONE;
		u.coef    = '0;
		u.use_hi  = 1'b0;
		u.alu     = a;
		return u;
	endfunction

	function automatic uop_t mc_f(input logic [WORD_W-1:0] c, input logic hi, input alu_t a);
		uop_t u;
		u        = op_f(a);
		u.mul_en = 1'b1;
		u.coef   = c;
		u.use_hi = hi;
		return u;
	endfunction

	function automatic uop_t mk_f(input key_sel_t k);
		uop_t u;
		u         = op_f(ALU_NOP);
		u.mul_en  = 1'b1;
		u.key_sel = k;
		return u;
	endfunction

	// step sequence: chain A (0..20), chain B (21..51), result (52)
	function automatic uop_t uop_f(input logic [STEP_W-1:0] s);
		uop_t u;
		unique case (s)
			6'd0:  u = op_f(ALU_XA);
			6'd1:  u = mk_f(KEY_A1);
			6'd2:  u = mc_f(32'h10FA_9605, 1'b1, ALU_LOAD);
			6'd3:  u = op_f(ALU_SUB);
			6'd4:  u = mc_f(32'h79F8_A395, 1'b0, ALU_NOP);
			6'd5:  u = mc_f(32'h689B_6B9F, 1'b1, ALU_LOAD);
			6'd6:  u = op_f(ALU_ADD);
			6'd7:  u = mc_f(32'hEA97_0001, 1'b0, ALU_NOP);
			6'd8:  u = mc_f(32'h3C10_1569, 1'b1, ALU_LOAD);
			6'd9:  u = op_f(ALU_SUB);
			6'd10: u = op_f(ALU_R3A);
			6'd11: u = mk_f(KEY_A2);
			6'd12: u = mc_f(32'h3CE8_EC25, 1'b1, ALU_LOAD);
			6'd13: u = op_f(ALU_SUB);
			6'd14: u = mc_f(32'h59C3_AF2D, 1'b0, ALU_NOP);
			6'd15: u = mc_f(32'h2232_E0F1, 1'b1, ALU_LOAD);
			6'd16: u = op_f(ALU_SUB);
			6'd17: u = mc_f(32'h1EC9_0001, 1'b0, ALU_NOP);
			6'd18: u = mc_f(32'h35BD_1EC9, 1'b1, ALU_LOAD);
			6'd19: u = op_f(ALU_ADD);
			6'd20: u = op_f(ALU_FINA);
			6'd21: u = op_f(ALU_XB);
			6'd22: u = mk_f(KEY_B1);
			6'd23: u = op_f(ALU_MOVE);
			6'd24: u = mc_f(32'hB111_0000, 1'b0, ALU_NOP);
			6'd25: u = mc_f(32'h3067_4EEF, 1'b1, ALU_LOAD);
			6'd26: u = op_f(ALU_SUB);
			6'd27: u = mc_f(32'h5B9F_0000, 1'b0, ALU_NOP);
			6'd28: u = mc_f(32'h78F7_A461, 1'b1, ALU_LOAD);
			6'd29: u = op_f(ALU_SUB);
			// high-half term first: result is c1*hi - c2*t
			6'd30: u = mc_f(32'h12CE_B96D, 1'b1, ALU_NOP);
			6'd31: u = mc_f(32'h4693_0000, 1'b0, ALU_LOAD);
			6'd32: u = op_f(ALU_SUB);
			6'd33: u = mc_f(32'h1D83_0000, 1'b0, ALU_NOP);
			6'd34: u = mc_f(32'h257E_1D83, 1'b1, ALU_LOAD);
			6'd35: u = op_f(ALU_ADD);
			6'd36: u = op_f(ALU_R3B);
			6'd37: u = mk_f(KEY_B2);
			6'd38: u = op_f(ALU_MOVE);
			6'd39: u = mc_f(32'h16F5_0000, 1'b0, ALU_NOP);
			6'd40: u = mc_f(32'h5D8B_E90B, 1'b1, ALU_LOAD);
			6'd41: u = op_f(ALU_SUB);
			6'd42: u = mc_f(32'h96FF_0000, 1'b0, ALU_NOP);
			6'd43: u = mc_f(32'h2C7C_6901, 1'b1, ALU_LOAD);
			6'd44: u = op_f(ALU_SUB);
			6'd45: u = mc_f(32'h2B89_0000, 1'b0, ALU_NOP);
			6'd46: u = mc_f(32'h7C93_2B89, 1'b1, ALU_LOAD);
			6'd47: u = op_f(ALU_ADD);
			6'd48: u = mc_f(32'h9F69_0000, 1'b0, ALU_NOP);
			6'd49: u = mc_f(32'h405B_6097, 1'b1, ALU_LOAD);
			6'd50: u = op_f(ALU_SUB);
			6'd51: u = op_f(ALU_FINB);
			6'd52: u = op_f(ALU_DONE);
			default: u = op_f(ALU_NOP);
		endcase
		return u;
	endfunction

endpackage

// ===== src/dual_chain_multiply_hash_core.sv =====
`timescale 1ns / 1ps

// Dual-chain multiply hash. Each input beat carries one pair of little-endian
// message words; both chains are advanced by a fixed 53-step sequence on a
// single shared 32x32 multiplier, so a pair occupies the block from
// acceptance to the end of its sequence and s_tready is low meanwhile. A
// beat with s_tlast set yields one output beat with the XOR of the two chains
// and clears them; the next pair may be taken while that result still
// waits, but a further final pair holds in its last step until the output
// register is free. Key writes take effect from the next pair and are
// expected only while the block is idle.
module dual_chain_multiply_hash_core
	import dcmh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [TDATA_W-1:0]   s_tdata,   // word_even[31:0], word_odd[63:32]
	input  logic                 s_tlast,   // last_pair
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TDATA_W-1:0]   m_tdata,   // hash_low[31:0], hash_high[63:32]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data
);

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   step_q;
	logic                last_q;
	logic [WORD_W-1:0]   w0_q, w1_q;
	logic [WORD_W-1:0]   key_a1_q, key_a2_q, key_b1_q, key_b2_q;
	logic [WORD_W-1:0]   a_mix_q, a_sum_q, b_mix_q, b_sum_q;
	logic [WORD_W-1:0]   t_q, acc_q, p_q;
	logic [WORD_W-1:0]   hash_low_q, hash_high_q;
	logic                out_valid_q;

	uop_t                uop;
	logic [WORD_W-1:0]   coef_mul, opnd_mul, prod;
	logic                accept, run, at_last, done_fire, exec;

	assign accept    = s_tvalid && s_tready;
	assign at_last   = (step_q == STEP_LAST);
	assign done_fire = run && at_last && !(last_q && out_valid_q && !m_tready);
	assign exec      = run && (!at_last || done_fire);
	assign uop       = uop_f(step_q);
	assign cfg_ready = 1'b1;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (done_fire) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		s_tready = 1'b0;
		run      = 1'b0;
		unique case (state_q)
			ST_IDLE: s_tready = 1'b1;
			ST_RUN:  run      = 1'b1;
			default: s_tready = 1'b0;
		endcase
	end

	always_comb begin
		unique case (uop.key_sel)
			KEY_A1:  coef_mul = key_a1_q;
			KEY_A2:  coef_mul = key_a2_q;
			KEY_B1:  coef_mul = key_b1_q;
			KEY_B2:  coef_mul = key_b2_q;
			default: coef_mul = uop.coef;
		endcase
		opnd_mul = uop.use_hi ? {16'h0000, t_q[WORD_W-1:16]} : t_q;
	end

	assign prod = coef_mul * opnd_mul;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
			key_a1_q    <= KEY_A1_OFS + 32'd1;
			key_a2_q    <= KEY_A2_OFS + 32'd1;
			key_b1_q    <= 32'd1;
			key_b2_q    <= 32'd1;
			a_mix_q     <= '0;
			a_sum_q     <= '0;
			b_mix_q     <= '0;
			b_sum_q     <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (exec && !at_last) begin
				step_q <= step_q + STEP_W'(1);
			end
			if (done_fire && last_q) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_KEY_LOW: begin
						key_a1_q <= (cfg_data | 32'd1) + KEY_A1_OFS;
						key_b1_q <= cfg_data | 32'd1;
					end
					REG_KEY_HIGH: begin
						key_a2_q <= (cfg_data | 32'd1) + KEY_A2_OFS;
						key_b2_q <= cfg_data | 32'd1;
					end
					default: ;
				endcase
			end
			if (exec) begin
				unique case (uop.alu)
					ALU_R3A: a_sum_q <= a_sum_q + t_q;
					ALU_R3B: b_sum_q <= b_sum_q + t_q;
					ALU_FINA: begin
						a_mix_q <= t_q;
						a_sum_q <= a_sum_q + t_q;
					end
					ALU_FINB: begin
						b_mix_q <= t_q;
						b_sum_q <= b_sum_q + t_q;
					end
					ALU_DONE: begin
						if (last_q) begin
							a_mix_q <= '0;
							a_sum_q <= '0;
							b_mix_q <= '0;
							b_sum_q <= '0;
						end
					end
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			w0_q   <= s_tdata[WORD_W-1:0];
			w1_q   <= s_tdata[TDATA_W-1:WORD_W];
			last_q <= s_tlast;
		end
		if (exec) begin
			if (uop.mul_en) p_q <= prod;
			unique case (uop.alu)
				ALU_LOAD: acc_q <= p_q;
				ALU_ADD:  t_q   <= acc_q + p_q;
				ALU_SUB:  t_q   <= acc_q - p_q;
				ALU_MOVE: t_q   <= p_q;
				ALU_XA:   t_q   <= w0_q + a_mix_q;
				ALU_XB:   t_q   <= w0_q + b_mix_q;
				ALU_R3A:  t_q   <= t_q + w1_q;
				ALU_R3B:  t_q   <= t_q + w1_q;
				ALU_DONE: begin
					if (last_q) begin
						hash_low_q  <= a_mix_q ^ b_mix_q;
						hash_high_q <= a_sum_q ^ b_sum_q;
					end
				end
				default: ;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {hash_high_q, hash_low_q};

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		step_q <= STEP_LAST)
		else $error("sequencer step out of range");

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q == ST_RUN) && (step_q == '0))
		else $error("accepted pair did not start the sequence");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(done_fire && last_q))
		else $error("result raised without a finished final pair");

	a_chains_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(done_fire && last_q) |=>
			(a_mix_q == '0) && (a_sum_q == '0) && (b_mix_q == '0) && (b_sum_q == '0))
		else $error("chains not cleared after final pair");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> $stable(m_tdata))
		else $error("pending result overwritten");

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
	import dcmh_pkg::*;

	typedef logic [WORD_W-1:0] word_t;

	typedef struct packed {
		word_t hi;
		word_t lo;
	} hash_t;

	typedef struct {
		bit       is_key;
		cfg_reg_t idx;
		word_t    a;
		word_t    b;
		bit       last;
		bit       typed;
		hash_t    want;
	} row_t;

	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE      = 64;

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [TDATA_W-1:0]   s_tdata   = '0;
	logic                 s_tlast   = 1'b0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [TDATA_W-1:0]   m_tdata;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	cfg_reg_t             cfg_index = REG_KEY_LOW;
	logic [WORD_W-1:0]    cfg_data  = '0;

	dual_chain_multiply_hash_core DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// chain state and key copies
	word_t key_lo_m, key_hi_m;
	word_t a_mix, a_sum, b_mix, b_sum;
	hash_t pending_hashes[$];
	int    errors  = 0;
	bit    idle_on = 1'b0;
	int    quiet   = 0;
	int    stall_left = 0;

	function automatic word_t madd(input word_t c1, input word_t c2, input word_t x);
		word_t p, q;
		p = c1 * x;
		q = c2 * {16'h0, x[31:16]};
		return p + q;
	endfunction

	function automatic word_t msub(input word_t c1, input word_t c2, input word_t x);
		word_t p, q;
		p = c1 * x;
		q = c2 * {16'h0, x[31:16]};
		return p - q;
	endfunction

	function automatic bit absorb_pair(input word_t w0, input word_t w1, input bit lst,
			output hash_t h);
		word_t m1, m2, x, t, r3, s, p, q;
		m1 = (key_lo_m | 32'h1) + KEY_A1_OFS;
		m2 = (key_hi_m | 32'h1) + KEY_A2_OFS;
		x  = w0 + a_mix;
		t  = msub(m1, 32'h10FA_9605, x);
		t  = madd(32'h79F8_A395, 32'h689B_6B9F, t);
		r3 = msub(32'hEA97_0001, 32'h3C10_1569, t);
		s  = a_sum + r3;
		t  = r3 + w1;
		t  = msub(m2, 32'h3CE8_EC25, t);
		t  = msub(32'h59C3_AF2D, 32'h2232_E0F1, t);
		a_mix = madd(32'h1EC9_0001, 32'h35BD_1EC9, t);
		a_sum = s + a_mix;

		m1 = key_lo_m | 32'h1;
		m2 = key_hi_m | 32'h1;
		x  = w0 + b_mix;
		t  = x * m1;
		t  = msub(32'hB111_0000, 32'h3067_4EEF, t);
		t  = msub(32'h5B9F_0000, 32'h78F7_A461, t);
		p  = 32'h12CE_B96D * {16'h0, t[31:16]};
		q  = 32'h4693_0000 * t;
		t  = p - q;
		r3 = madd(32'h1D83_0000, 32'h257E_1D83, t);
		x  = r3 + w1;
		t  = m2 * x;
		t  = msub(32'h16F5_0000, 32'h5D8B_E90B, t);
		t  = msub(32'h96FF_0000, 32'h2C7C_6901, t);
		t  = madd(32'h2B89_0000, 32'h7C93_2B89, t);
		b_mix = msub(32'h9F69_0000, 32'h405B_6097, t);
		b_sum = b_mix + b_sum + r3;

		h.lo = a_mix ^ b_mix;
		h.hi = a_sum ^ b_sum;
		if (lst) begin
			a_mix = '0;
			a_sum = '0;
			b_mix = '0;
			b_sum = '0;
		end
		return lst;
	endfunction

	function automatic word_t rnd_word();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			2: return word_t'(1) << $urandom_range(0, 31);
			3: return ~(word_t'(1) << $urandom_range(0, 31));
			4: return word_t'($urandom_range(0, 65535));
			default: return $urandom;
		endcase
	endfunction

	task automatic offer_pair(input word_t w0, input word_t w1, input bit lst,
			input bit typed, input hash_t typed_hash);
		hash_t h;
		if (idle_on && $urandom_range(0, 99) < 30) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 70)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {w1, w0};
		s_tlast  <= lst;
		do @(posedge clk); while (!s_tready);
		if (absorb_pair(w0, w1, lst, h))
			pending_hashes.push_back(typed ? typed_hash : h);
	endtask

	// block must be idle: drain results, then let any non-final pair finish
	task automatic settle_and_write(input cfg_reg_t idx, input word_t val);
		s_tvalid <= 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_KEY_LOW:  key_lo_m = val;
			REG_KEY_HIGH: key_hi_m = val;
		endcase
	endtask

	row_t plan [0:21] = '{
		'{0, REG_KEY_LOW,  32'h0000_0000, 32'h0000_0000, 1, 1, '0},
		'{0, REG_KEY_LOW,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, '0},
		'{0, REG_KEY_LOW,  32'h0000_0000, 32'hFFFF_FFFF, 0, 0, '0},
		'{0, REG_KEY_LOW,  32'hFFFF_FFFF, 32'h0000_0000, 1, 0, '0},
		'{0, REG_KEY_LOW,  32'h8000_0000, 32'h0000_0001, 0, 0, '0},
		'{0, REG_KEY_LOW,  32'h0000_FFFF, 32'h0001_0000, 0, 0, '0},
		'{0, REG_KEY_LOW,  32'h1234_5678, 32'h9ABC_DEF0, 1, 0, '0},
		'{1, REG_KEY_LOW,  32'hFFFF_FFFF, 32'h0,         0, 0, '0},
		'{1, REG_KEY_HIGH, 32'hFFFF_FFFF, 32'h0,         0, 0, '0},
		'{0, REG_KEY_LOW,  32'h0000_0000, 32'h0000_0000, 1, 1, '0},
		'{0, REG_KEY_LOW,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 0, '0},
		'{0, REG_KEY_LOW,  32'h0000_0001, 32'h8000_0000, 1, 0, '0},
		'{0, REG_KEY_LOW,  32'hDEAD_BEEF, 32'h0123_4567, 0, 0, '0},
		// key change between pairs of one message
		'{1, REG_KEY_LOW,  32'h0000_0000, 32'h0,         0, 0, '0},
		'{0, REG_KEY_LOW,  32'h89AB_CDEF, 32'hFEDC_BA98, 1, 0, '0},
		'{1, REG_KEY_HIGH, 32'h8000_0000, 32'h0,         0, 0, '0},
		'{0, REG_KEY_LOW,  32'h5555_5555, 32'hAAAA_AAAA, 0, 0, '0},
		'{0, REG_KEY_LOW,  32'hAAAA_AAAA, 32'h5555_5555, 0, 0, '0},
		'{0, REG_KEY_LOW,  32'hFFFF_0000, 32'h0000_FFFF, 1, 0, '0},
		'{1, REG_KEY_LOW,  32'h7FFF_FFFE, 32'h0,         0, 0, '0},
		'{0, REG_KEY_LOW,  32'hFFFF_FFFF, 32'h0000_0000, 1, 0, '0},
		'{0, REG_KEY_LOW,  32'h0000_0000, 32'h0000_0000, 1, 1, '0}
	};

	initial begin
		word_t kl, kh;
		int    sent, len;
		bit    lst;
		key_lo_m = '0;
		key_hi_m = '0;
		a_mix = '0;
		a_sum = '0;
		b_mix = '0;
		b_sum = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].is_key)
				settle_and_write(plan[i].idx, plan[i].a);
			else
				offer_pair(plan[i].a, plan[i].b, plan[i].last, plan[i].typed, plan[i].want);
		end

		for (int ph = 0; ph < 10; ph++) begin
			idle_on = (ph != 4);
			case (ph)
				0: begin kl = '0;        kh = '1;        end
				1: begin kl = '1;        kh = '0;        end
				2: begin kl = '1;        kh = '1;        end
				3: begin kl = '0;        kh = '0;        end
				default: begin kl = $urandom; kh = $urandom; end
			endcase
			settle_and_write(REG_KEY_LOW, kl);
			settle_and_write(REG_KEY_HIGH, kh);
			sent = 0;
			while (sent < 123) begin
				len = ($urandom_range(0, 99) < 40) ? 1 : $urandom_range(2, 8);
				for (int i = 0; i < len; i++) begin
					lst = (i == len - 1);
					offer_pair(rnd_word(), rnd_word(), lst, 1'b0, '0);
					sent++;
					if (!lst && $urandom_range(0, 99) < 3)
						settle_and_write(cfg_reg_t'($urandom_range(0, 1)), $urandom);
				end
			end
		end

		s_tvalid <= 1'b0;
		while (pending_hashes.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
		if (errors == 0)
			$display("[dual_chain_multiply_hash_core] OK");
		else
			$display("[dual_chain_multiply_hash_core] ERROR");
		$finish;
	end

	always @(posedge clk) begin : rx_side
		hash_t want;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (pending_hashes.size() == 0) begin
					$error("unexpected result beat: %h", m_tdata);
					errors++;
				end else begin
					want = pending_hashes.pop_front();
					if (m_tdata[31:0] !== want.lo) begin
						$error("hash_low: expected %h, got %h", want.lo, m_tdata[31:0]);
						errors++;
					end
					if (m_tdata[63:32] !== want.hi) begin
						$error("hash_high: expected %h, got %h", want.hi, m_tdata[63:32]);
						errors++;
					end
				end
			end
			// occasional long stall so a second final pair has to wait
			if (stall_left > 0) begin
				stall_left <= stall_left - 1;
				m_tready   <= 1'b0;
			end else if (idle_on && m_tvalid && $urandom_range(0, 99) < 5) begin
				stall_left <= $urandom_range(60, 150);
				m_tready   <= 1'b0;
			end else begin
				m_tready <= idle_on ? ($urandom_range(0, 99) >= 30) : 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
				quiet <= 0;
			else
				quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("[dual_chain_multiply_hash_core] ERROR");
				$finish;
			end
		end
	end

endmodule
